/* rtl/ttip_pkg.sv */
`timescale 1ns / 1ps

package ttip_pkg;

   // Defaults for the top-level parameters
   localparam int POS_BITS_DEF   = 16;
   localparam int VALUE_BITS_DEF = 64;

   // Field widths fixed by the interface
   localparam int CH_W     = 8;
   localparam int RADIX_W  = 6;
   localparam int DIGIT_W  = 6;
   localparam int VALUE_W  = 64;
   localparam int OFFSET_W = 16;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
   localparam logic [RADIX_W-1:0] BASE_ONE    = 6'd1;
   localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;
   localparam logic [DIGIT_W-1:0] DIGIT_NONE  = 6'd36;

   // Character codes
   localparam logic [CH_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CH_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CH_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CH_W-1:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [CH_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CH_W-1:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [CH_W-1:0] CHAR_LO_X  = 8'h78;
   localparam logic [CH_W-1:0] CHAR_UP_X  = 8'h58;
   localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CH_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CHAR_OFS_A = 8'd10;

   // One classified character as it travels from front to back
   typedef struct packed {
      logic               first;
      logic [DIGIT_W-1:0] digit;
      logic               is_space;
      logic               is_sign;
      logic               is_minus;
      logic               is_zero;
      logic               is_x;
   } char_class_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic pop;
      logic emit;
   } back_status_type;

   // Digit value of a character, DIGIT_NONE when it is no digit at all
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
      logic [CH_W-1:0] d;
      d = {2'b00, DIGIT_NONE};
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = c - CHAR_0;
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         d = c - CHAR_LO_A + CHAR_OFS_A;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         d = c - CHAR_UP_A + CHAR_OFS_A;
      end
      return d[DIGIT_W-1:0];
   endfunction

endpackage

/* rtl/ttip_front.sv */
`timescale 1ns / 1ps

module ttip_front (
   input  logic [ttip_pkg::CH_W-1:0] ch,
   input  logic                      first,
   output ttip_pkg::char_class_type  cls
);
   import ttip_pkg::*;

   // Classify the incoming character
   always_comb begin
      cls.first    = first;
      cls.digit    = digit_of(ch);
      cls.is_space = (ch == CHAR_SPACE) || (ch == CHAR_TAB) ||
                     (ch == CHAR_LF) || (ch == CHAR_CR);
      cls.is_sign  = (ch == CHAR_MINUS) || (ch == CHAR_PLUS);
      cls.is_minus = (ch == CHAR_MINUS);
      cls.is_zero  = (ch == CHAR_0);
      cls.is_x     = (ch == CHAR_LO_X) || (ch == CHAR_UP_X);
   end

endmodule

/* rtl/ttip_queue.sv */
`timescale 1ns / 1ps

module ttip_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ttip_pkg::char_class_type push_data,
   input  logic                     pop,
   output ttip_pkg::char_class_type head,
   output ttip_pkg::q_status_type   status
);
   import ttip_pkg::*;

   char_class_type entry_ff [2];
   logic           wr_ptr_ff;
   logic           rd_ptr_ff;
   logic [1:0]     count_ff;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

/* rtl/ttip_back.sv */
`timescale 1ns / 1ps

module ttip_back #(
   parameter int POS_BITS   = ttip_pkg::POS_BITS_DEF,
   parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ttip_pkg::RADIX_W-1:0]  radix,
   input  ttip_pkg::char_class_type      head,
   input  ttip_pkg::q_status_type        q_status,
   output ttip_pkg::back_status_type     status,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [ttip_pkg::VALUE_W-1:0]  rsp_value,
   output logic [ttip_pkg::OFFSET_W-1:0] rsp_end_offset
);
   import ttip_pkg::*;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_SIGNED,
      PH_ZERO,
      PH_PREFIX,
      PH_DIGITS
   } phase_type;

   phase_type             phase_ff, phase_in, cur_phase;
   logic                  negative_ff, negative_in, cur_neg;
   logic [RADIX_W-1:0]    base_ff, base_in, cur_base, eff_base;
   logic [VALUE_BITS-1:0] acc_ff, acc_in, cur_acc, mac;
   logic [POS_BITS-1:0]   pos_ff, pos_in, cur_pos, pos_inc1, pos_inc2;
   logic [VALUE_BITS+RADIX_W-1:0] mac_full;

   logic                  emit;
   logic [VALUE_BITS-1:0] emit_mag;
   logic [POS_BITS-1:0]   emit_off;
   logic signed [VALUE_BITS-1:0] signed_val;
   logic [31:0]           off_wide;
   logic                  out_free;
   logic                  pop;
   logic [DIGIT_W-1:0]    head_digit;

   logic                  rsp_valid_ff;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [OFFSET_W-1:0]   rsp_end_offset_ff, rsp_end_offset_in;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pop         = !q_status.empty && out_free;
   assign status.pop  = pop;
   assign status.emit = pop && emit;
   assign head_digit  = head.digit;

   // Restart state on a first character
   always_comb begin
      if (head.first) begin
         cur_phase = PH_LEAD;
         cur_neg   = 1'b0;
         cur_base  = radix;
         cur_acc   = '0;
         cur_pos   = '0;
      end else begin
         cur_phase = phase_ff;
         cur_neg   = negative_ff;
         cur_base  = base_ff;
         cur_acc   = acc_ff;
         cur_pos   = pos_ff;
      end
   end

   // Resolve automatic base for the digit step
   always_comb begin
      eff_base = cur_base;
      if (cur_base == BASE_AUTO) begin
         eff_base = (cur_phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
      end
   end

   // Multiply-add by the base, wrap to the value width
   assign mac_full = {{RADIX_W{1'b0}}, cur_acc} * {{VALUE_BITS{1'b0}}, eff_base}
                     + {{VALUE_BITS{1'b0}}, head_digit};
   assign mac      = mac_full[VALUE_BITS-1:0];

   // Saturating position steps
   assign pos_inc1 = (cur_pos == POS_MAX) ? cur_pos : cur_pos + 1'b1;
   assign pos_inc2 = (cur_pos >= POS_MAX - 1'b1) ? POS_MAX : cur_pos + 2'd2;

   // Parse step for one character
   always_comb begin
      phase_in    = cur_phase;
      negative_in = cur_neg;
      base_in     = cur_base;
      acc_in      = cur_acc;
      pos_in      = cur_pos;
      emit        = 1'b0;
      emit_mag    = cur_acc;
      emit_off    = cur_pos;
      unique case (cur_phase)
         PH_IDLE: begin
         end
         PH_LEAD, PH_SIGNED: begin
            if (cur_phase == PH_LEAD && head.is_space) begin
               pos_in = pos_inc1;
            end else if (cur_phase == PH_LEAD && head.is_sign) begin
               negative_in = head.is_minus;
               pos_in      = pos_inc1;
               phase_in    = PH_SIGNED;
            end else if (cur_base == BASE_ONE || cur_base > BASE_MAX) begin
               emit     = 1'b1;
               emit_mag = '0;
               emit_off = '0;
            end else if (head.is_zero &&
                         (cur_base == BASE_AUTO || cur_base == BASE_HEX)) begin
               acc_in   = '0;
               pos_in   = pos_inc1;
               phase_in = PH_ZERO;
            end else begin
               base_in = eff_base;
               if (head_digit < eff_base) begin
                  acc_in   = {{(VALUE_BITS-DIGIT_W){1'b0}}, head_digit};
                  pos_in   = pos_inc1;
                  phase_in = PH_DIGITS;
               end else begin
                  emit     = 1'b1;
                  emit_mag = '0;
                  emit_off = '0;
               end
            end
         end
         PH_ZERO, PH_DIGITS: begin
            if (cur_phase == PH_ZERO && head.is_x) begin
               phase_in = PH_PREFIX;
            end else begin
               base_in = eff_base;
               if (head_digit < eff_base) begin
                  acc_in   = mac;
                  pos_in   = pos_inc1;
                  phase_in = PH_DIGITS;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         PH_PREFIX: begin
            base_in = BASE_HEX;
            if (head_digit < BASE_HEX) begin
               pos_in   = pos_inc2;
               acc_in   = {{(VALUE_BITS-DIGIT_W){1'b0}}, head_digit};
               phase_in = PH_DIGITS;
            end else begin
               emit     = 1'b1;
               emit_mag = '0;
            end
         end
         default: begin
         end
      endcase
      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   // Form the result: negate, sign-extend, saturate the offset
   always_comb begin
      signed_val        = cur_neg ? -emit_mag : emit_mag;
      rsp_value_in      = VALUE_W'(signed_val);
      off_wide          = 32'(emit_off);
      rsp_end_offset_in = (off_wide > 32'h0000_FFFF) ? 16'hFFFF : off_wide[OFFSET_W-1:0];
   end

   // Hold parse state between characters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         negative_ff <= 1'b0;
         base_ff     <= '0;
         acc_ff      <= '0;
         pos_ff      <= '0;
      end else if (pop) begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         base_ff     <= base_in;
         acc_ff      <= acc_in;
         pos_ff      <= pos_in;
      end
   end

   // Output register: load on emit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_value_ff      <= rsp_value_in;
         rsp_end_offset_ff <= rsp_end_offset_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_end_offset = rsp_end_offset_ff;

endmodule

/* rtl/text_to_integer_parser.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_ch[7:0], req_first
// rsp_      out        rsp_valid/rsp_stall  rsp_value[63:0] signed, rsp_end_offset[15:0]
// csr_      in         csr_wr_en            csr_wr_data[5:0] (radix)
//
// One character per cycle sustained while no result waits under rsp_stall; a result
// passes from its stop character through classify into a two-entry queue, then one
// parse step with a multiply-add by the base, then the output register.
// Reset (synchronous, active high) empties the queue, drops any string in progress
// and sets radix to 10.
// req_stall rises only while the queue is full; the queue fills when a result
// waits under rsp_stall.

module text_to_integer_parser #(
   parameter int POS_BITS   = ttip_pkg::POS_BITS_DEF,
   parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ttip_pkg::CH_W-1:0]     req_ch,
   input  logic                          req_first,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ttip_pkg::VALUE_W-1:0]  rsp_value,
   output logic [ttip_pkg::OFFSET_W-1:0] rsp_end_offset,
   input  logic                          csr_wr_en,
   input  logic [ttip_pkg::RADIX_W-1:0]  csr_wr_data
);
   import ttip_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   char_class_type     front_cls;
   char_class_type     q_head;
   q_status_type       q_status;
   back_status_type    back_status;
   logic               req_accept;

   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !q_status.full;

   // Hold the radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_wr_en) begin
         radix_ff <= csr_wr_data;
      end
   end

   ttip_front u_front (
      .ch    (req_ch),
      .first (req_first),
      .cls   (front_cls)
   );

   ttip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_cls),
      .pop       (back_status.pop),
      .head      (q_head),
      .status    (q_status)
   );

   ttip_back #(
      .POS_BITS   (POS_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .radix          (radix_ff),
      .head           (q_head),
      .q_status       (q_status),
      .status         (back_status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_value),
      .rsp_end_offset (rsp_end_offset)
   );

`ifndef SYNTHESIS
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_status.emit |-> (back_status.pop && !q_status.empty))
      else $error("result emitted without a queued transaction");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      back_status.emit |=> rsp_valid)
      else $error("emitted result not presented");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (req_accept && q_status.empty) |=> !q_status.empty)
      else $error("accepted transaction lost in queue");
`endif

endmodule

/* verif/text_to_integer_parser_test.sv */
`timescale 1ns / 1ps

module text_to_integer_parser_test;
   import ttip_pkg::*;

   localparam int IDLE_PCT     = 27;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int TAIL_CYCLES  = 10;
   localparam int PHASE_ITEMS  = 140;
   localparam int POS_LIMIT    = (1 << POS_BITS_DEF) - 1;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_LEAD,
      SCAN_SIGNED,
      SCAN_ZERO,
      SCAN_PREFIX,
      SCAN_DIGITS
   } scan_state_type;

   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            first;
   } char_txn_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [OFFSET_W-1:0] end_offset;
   } parse_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CH_W-1:0]      req_ch = '0;
   logic                 req_first = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VALUE_W-1:0]   rsp_value;
   logic [OFFSET_W-1:0]  rsp_end_offset;
   logic                 csr_wr_en;
   logic [RADIX_W-1:0]   csr_wr_data;

   char_txn_type     char_queue[$];
   parse_result_type number_queue[$];

   bit req_fire;
   bit steady;
   int error_count = 0;
   int quiet_cycles = 0;

   // Shadow of the parser state
   logic [RADIX_W-1:0] radix_reg;
   scan_state_type     scan_state = SCAN_IDLE;
   logic               scan_negative = 1'b0;
   logic [RADIX_W-1:0] scan_base = '0;
   logic [VALUE_W-1:0] scan_acc = '0;
   int unsigned        scan_pos = 0;

   text_to_integer_parser #(
      .POS_BITS   (POS_BITS_DEF),
      .VALUE_BITS (VALUE_BITS_DEF)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_end_offset (rsp_end_offset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Digit value 0..35, or DIGIT_NONE for anything that is no digit
   function automatic int char_digit(input logic [CH_W-1:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return c - CHAR_0;
      if (c >= CHAR_LO_A && c <= CHAR_LO_Z) return c - CHAR_LO_A + 10;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return c - CHAR_UP_A + 10;
      return int'(DIGIT_NONE);
   endfunction

   function automatic logic [CH_W-1:0] digit_char(input int d);
      if (d < 10) return CH_W'(CHAR_0 + d);
      return CH_W'(($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + d - 10);
   endfunction

   task automatic bump_pos();
      if (scan_pos < POS_LIMIT) scan_pos++;
   endtask

   // Close the number at the stop character
   task automatic close_number(input logic [VALUE_W-1:0] mag, input int unsigned off,
                               output parse_result_type res);
      res.value      = scan_negative ? -mag : mag;
      res.end_offset = (off > 16'hFFFF) ? 16'hFFFF : off[OFFSET_W-1:0];
      scan_state     = SCAN_IDLE;
   endtask

   task automatic take_digit(input logic [CH_W-1:0] c, output bit produced,
                             output parse_result_type res);
      int d;
      d = char_digit(c);
      produced = 1'b0;
      if (d < int'(scan_base)) begin
         scan_acc   = scan_acc * VALUE_W'(scan_base) + VALUE_W'(d);
         bump_pos();
         scan_state = SCAN_DIGITS;
      end else begin
         close_number(scan_acc, scan_pos, res);
         produced = 1'b1;
      end
   endtask

   // First character after whitespace and sign
   task automatic take_lead_digit(input logic [CH_W-1:0] c, output bit produced,
                                  output parse_result_type res);
      int d;
      produced = 1'b0;
      if (scan_base == BASE_ONE || scan_base > BASE_MAX) begin
         close_number('0, 0, res);
         produced = 1'b1;
      end else if (c == CHAR_0 && (scan_base == BASE_AUTO || scan_base == BASE_HEX)) begin
         scan_acc   = '0;
         bump_pos();
         scan_state = SCAN_ZERO;
      end else begin
         if (scan_base == BASE_AUTO) scan_base = BASE_DEC;
         d = char_digit(c);
         if (d < int'(scan_base)) begin
            scan_acc   = VALUE_W'(d);
            bump_pos();
            scan_state = SCAN_DIGITS;
         end else begin
            close_number('0, 0, res);
            produced = 1'b1;
         end
      end
   endtask

   // Advance the shadow parser by one accepted character
   task automatic parse_char(input logic [CH_W-1:0] c, input logic first,
                             output bit produced, output parse_result_type res);
      int d;
      produced = 1'b0;
      res      = '0;
      if (first) begin
         scan_state    = SCAN_LEAD;
         scan_negative = 1'b0;
         scan_base     = radix_reg;
         scan_acc      = '0;
         scan_pos      = 0;
      end
      case (scan_state)
         SCAN_LEAD: begin
            if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR) begin
               bump_pos();
            end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
               scan_negative = (c == CHAR_MINUS);
               bump_pos();
               scan_state    = SCAN_SIGNED;
            end else begin
               take_lead_digit(c, produced, res);
            end
         end
         SCAN_SIGNED: take_lead_digit(c, produced, res);
         SCAN_ZERO: begin
            if (c == CHAR_LO_X || c == CHAR_UP_X) begin
               scan_state = SCAN_PREFIX;
            end else begin
               if (scan_base == BASE_AUTO) scan_base = BASE_OCT;
               take_digit(c, produced, res);
            end
         end
         SCAN_PREFIX: begin
            scan_base = BASE_HEX;
            d = char_digit(c);
            if (d < 16) begin
               bump_pos();
               bump_pos();
               scan_acc   = VALUE_W'(d);
               scan_state = SCAN_DIGITS;
            end else begin
               close_number('0, scan_pos, res);
               produced = 1'b1;
            end
         end
         SCAN_DIGITS: take_digit(c, produced, res);
         default: ;
      endcase
   endtask

   task automatic push_char(input logic [CH_W-1:0] c, input logic first);
      char_queue.push_back(char_txn_type'{ch: c, first: first});
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
   endtask

   // Wait until the block has nothing left, then write the radix
   task automatic set_radix(input logic [RADIX_W-1:0] v);
      do @(negedge clock); while (char_queue.size() != 0 || number_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      radix_reg    = v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly well-formed numbers with random content, some noise
   task automatic random_string(input logic [RADIX_W-1:0] base_sel, output int counted);
      logic [CH_W-1:0] text[$];
      logic [CH_W-1:0] c;
      int              eff;
      int              n_dig;
      int              pick;
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 6)) text.push_back(CH_W'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
               0:       text.push_back(CHAR_SPACE);
               1:       text.push_back(CHAR_TAB);
               2:       text.push_back(CHAR_LF);
               default: text.push_back(CHAR_CR);
            endcase
         end
         pick = $urandom_range(0, 3);
         if (pick == 0) text.push_back(CHAR_MINUS);
         else if (pick == 1) text.push_back(CHAR_PLUS);
         eff = 10;
         if (base_sel >= 2 && base_sel <= BASE_MAX) eff = int'(base_sel);
         pick = $urandom_range(0, 3);
         if ((base_sel == BASE_AUTO && pick == 0) || (base_sel == BASE_HEX && pick < 2)) begin
            text.push_back(CHAR_0);
            text.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
            eff = 16;
         end else if (base_sel == BASE_AUTO && pick == 1) begin
            text.push_back(CHAR_0);
            eff = 8;
         end
         n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 6);
         for (int k = 0; k < n_dig; k++) begin
            if (base_sel == BASE_AUTO && eff == 10 && k == 0)
               text.push_back(digit_char($urandom_range(1, 9)));
            else
               text.push_back(digit_char($urandom_range(0, eff - 1)));
         end
         // Drop the stop character now and then so the next string restarts
         if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 3) == 0) begin
               c = CH_W'($urandom_range(0, 255));
            end else begin
               do c = CH_W'($urandom_range(0, 255));
               while (char_digit(c) != int'(DIGIT_NONE));
            end
            text.push_back(c);
         end
      end
      counted = text.size();
      foreach (text[i]) push_char(text[i], i == 0);
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 3)) push_char(CH_W'($urandom_range(0, 255)), 1'b0);
   endtask

   // Drive the request channel; hold a stalled transaction
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (char_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
         req_valid <= 1'b1;
         req_ch    <= char_queue[0].ch;
         req_first <= char_queue[0].first;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Apply random backpressure on results
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Check results, then predict from accepted characters
   always @(posedge clock) begin : monitor
      bit               produced;
      parse_result_type got;
      parse_result_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (number_queue.size() == 0) begin
            $display("%0t: unexpected result, value %0d end_offset %0d",
                     $time, $signed(rsp_value), rsp_end_offset);
            error_count++;
         end else begin
            want = number_queue.pop_front();
            if (rsp_value !== want.value) begin
               $display("%0t: value mismatch, expected %0d, actual %0d",
                        $time, $signed(want.value), $signed(rsp_value));
               error_count++;
            end
            if (rsp_end_offset !== want.end_offset) begin
               $display("%0t: end_offset mismatch, expected %0d, actual %0d",
                        $time, want.end_offset, rsp_end_offset);
               error_count++;
            end
         end
      end
      if (req_fire) begin
         parse_char(req_ch, req_first, produced, got);
         if (produced) number_queue.push_back(got);
         void'(char_queue.pop_front());
      end
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [RADIX_W-1:0] radix_plan[11];
      int                 phase_count;
      int                 n;
      radix_plan = '{BASE_DEC, BASE_AUTO, BASE_HEX, 6'd2, BASE_MAX, BASE_OCT, 6'd63,
                     BASE_ONE, BASE_AUTO, 6'd37, BASE_DEC};
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      steady        = 1'b0;
      radix_reg     = RADIX_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset radix, sign, no digits, idle, restart, NUL stop
      push_text(" -12!");
      push_char(CHAR_PLUS, 1'b1);
      push_char(8'hFF, 1'b0);
      push_char(CH_W'(CHAR_0 + 7), 1'b0);
      push_char(CH_W'(CHAR_0 + 5), 1'b1);
      push_char(CH_W'(CHAR_0 + 3), 1'b1);
      push_char(8'h00, 1'b0);
      // Auto base: hex prefix without hex digit, octal
      set_radix(BASE_AUTO);
      push_text("0xg");
      push_text("017 ");
      // Invalid base accepts nothing; the largest base takes z and Z as digits
      set_radix(BASE_ONE);
      push_text("5");
      set_radix(BASE_MAX);
      push_text("zZ.");

      // Random phases over a sweep of radix settings
      foreach (radix_plan[p]) begin
         set_radix(radix_plan[p]);
         steady = (p == 2);
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) begin
            random_string(radix_plan[p], n);
            phase_count += n;
         end
      end

      do @(negedge clock); while (char_queue.size() != 0 || number_queue.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* text_to_integer_parser.f */
rtl/ttip_pkg.sv
rtl/ttip_front.sv
rtl/ttip_queue.sv
rtl/ttip_back.sv
rtl/text_to_integer_parser.sv
verif/text_to_integer_parser_test.sv
